// File: rtl/pex_pkg.sv
package pex_pkg;

  // field types of the two channels
  typedef logic [1:0]  kind_t;
  typedef logic [15:0] value_t;
  typedef logic [7:0]  byte_t;
  typedef logic [4:0]  len_t;

  // result kinds
  localparam kind_t KIND_OFFSET = 2'd0;
  localparam kind_t KIND_CHAR   = 2'd1;
  localparam kind_t KIND_EOL    = 2'd2;

  // input word functions
  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_EOF  = 1'b1;

  // printable range is space up to but not including delete
  localparam byte_t CHAR_SPACE = 8'h20;
  localparam byte_t CHAR_DEL   = 8'h7F;

  // minimum run length after reset
  localparam len_t MIN_LEN_RESET = 5'd4;

  function automatic logic is_printable(input byte_t c);
    return (c >= CHAR_SPACE) && (c < CHAR_DEL);
  endfunction

  function automatic logic is_alnum(input byte_t c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

// File: rtl/pex_in_if.sv
interface pex_in_if;
  import pex_pkg::*;

  logic  valid;
  logic  ready;
  logic  func;
  byte_t byte_value;

  modport source (output valid, output func, output byte_value, input ready);
  modport sink   (input valid, input func, input byte_value, output ready);
endinterface

// File: rtl/pex_out_if.sv
interface pex_out_if;
  import pex_pkg::*;

  logic   valid;
  logic   ready;
  kind_t  kind;
  value_t value;
  logic   last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

// File: rtl/printable_run_extractor.sv
// Printable run extractor. Each input word is a data byte or an end-of-file
// marker; result words are a run start offset, a character, or an end of line,
// with last set on the final word caused by an input. The first bytes of a run
// are held in a window memory of MAX_WINDOW bytes with registered read. A
// byte that completes a reported window is followed by the offset word and
// then its window bytes, read back one byte per cycle through the memory read
// port while the output does not stall. No input word is taken until the
// results of the last word have been loaded for output, nor while a report is
// being read out. The window memory needs no clearing after reset: only
// entries written in the current window are read.
module printable_run_extractor #(
  parameter int MAX_WINDOW = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  pex_pkg::len_t    cfg_data,
  pex_in_if.sink           in_ch,
  pex_out_if.source        out_ch
);
  import pex_pkg::*;

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int LW = (CW > 5) ? CW : 5;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ONE  = 4'b0010,
    S_OFS  = 4'b0100,
    S_CHR  = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  len_t            min_len_r;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic            saw_r, saw_nxt;
  logic [15:0]     byte_off_r, byte_off_nxt;
  logic            in_run_r, in_run_nxt;
  logic [CW-1:0]   emit_n_r, emit_n_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  kind_t           pend_kind_r, pend_kind_nxt;
  value_t          pend_value_r, pend_value_nxt;
  logic            pend_last_r, pend_last_nxt;

  logic            out_valid_r, out_valid_nxt;
  kind_t           out_kind_r, out_kind_nxt;
  value_t          out_value_r, out_value_nxt;
  logic            out_last_r, out_last_nxt;

  byte_t           win_mem [MAX_WINDOW];
  byte_t           rd_data_r;
  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_addr, rd_addr;

  logic            accept;
  logic            out_free;
  logic            printable;
  logic [CW-1:0]   fill_inc;
  logic [LW-1:0]   eff_len;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign printable = is_printable(in_ch.byte_value);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = out_kind_r;
  assign out_ch.value = out_value_r;
  assign out_ch.last  = out_last_r;

  // effective run length, clamped to one .. MAX_WINDOW
  always_comb begin
    if (min_len_r == '0) begin
      eff_len = LW'(1);
    end else if (LW'(min_len_r) > LW'(MAX_WINDOW)) begin
      eff_len = LW'(MAX_WINDOW);
    end else begin
      eff_len = LW'(min_len_r);
    end
  end

  // window fill after this byte, held at the window size
  assign fill_inc = (fill_r < CW'(MAX_WINDOW)) ? CW'(fill_r + CW'(1)) : fill_r;

  // window write on an accepted printable byte outside a run
  assign wr_en   = accept && (in_ch.func == FUNC_DATA) && !in_run_r && printable &&
                   (fill_r < CW'(MAX_WINDOW));
  assign wr_addr = fill_r[AW-1:0];

  // sequencer and run tracking
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    saw_nxt        = saw_r;
    byte_off_nxt   = byte_off_r;
    in_run_nxt     = in_run_r;
    emit_n_nxt     = emit_n_r;
    cnt_nxt        = cnt_r;
    pend_kind_nxt  = pend_kind_r;
    pend_value_nxt = pend_value_r;
    pend_last_nxt  = pend_last_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_kind_nxt   = out_kind_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    rd_en          = 1'b0;
    rd_addr        = cnt_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pend_last_nxt = 1'b1;
          if (in_ch.func == FUNC_EOF) begin
            // end of file closes an open run and restarts the offset
            if (in_run_r) begin
              pend_kind_nxt  = KIND_EOL;
              pend_value_nxt = '0;
              state_nxt      = S_ONE;
            end
            fill_nxt     = '0;
            saw_nxt      = 1'b0;
            in_run_nxt   = 1'b0;
            byte_off_nxt = '0;
          end else begin
            byte_off_nxt = byte_off_r + 16'd1;
            if (in_run_r) begin
              // inside a reported run: pass the byte or close the run
              state_nxt = S_ONE;
              if (printable) begin
                pend_kind_nxt  = KIND_CHAR;
                pend_value_nxt = value_t'(in_ch.byte_value);
              end else begin
                pend_kind_nxt  = KIND_EOL;
                pend_value_nxt = '0;
                in_run_nxt     = 1'b0;
                fill_nxt       = '0;
                saw_nxt        = 1'b0;
              end
            end else if (!printable) begin
              fill_nxt = '0;
              saw_nxt  = 1'b0;
            end else if (LW'(fill_inc) >= eff_len) begin
              // window complete: report it or drop it
              if (saw_r || is_alnum(in_ch.byte_value)) begin
                pend_kind_nxt  = KIND_OFFSET;
                pend_value_nxt = byte_off_r + 16'd1 - 16'(fill_inc);
                emit_n_nxt     = fill_inc;
                in_run_nxt     = 1'b1;
                state_nxt      = S_OFS;
              end
              fill_nxt = '0;
              saw_nxt  = 1'b0;
            end else begin
              fill_nxt = fill_inc;
              saw_nxt  = saw_r || is_alnum(in_ch.byte_value);
            end
          end
        end
      end
      S_ONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pend_kind_r;
          out_value_nxt = pend_value_r;
          out_last_nxt  = pend_last_r;
          state_nxt     = S_IDLE;
        end
      end
      S_OFS: begin
        // offset word, and read the first window byte
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_OFFSET;
          out_value_nxt = pend_value_r;
          out_last_nxt  = 1'b0;
          rd_en         = 1'b1;
          rd_addr       = '0;
          cnt_nxt       = CW'(1);
          state_nxt     = S_CHR;
        end
      end
      S_CHR: begin
        // one window byte per word, next read issued as this one leaves
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_CHAR;
          out_value_nxt = value_t'(rd_data_r);
          out_last_nxt  = (cnt_r == emit_n_r);
          if (cnt_r == emit_n_r) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            cnt_nxt = CW'(cnt_r + CW'(1));
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // window memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_mem[wr_addr] <= in_ch.byte_value;
    end
    if (rd_en) begin
      rd_data_r <= win_mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_len_r   <= MIN_LEN_RESET;
      fill_r      <= '0;
      saw_r       <= 1'b0;
      byte_off_r  <= '0;
      in_run_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      saw_r       <= saw_nxt;
      byte_off_r  <= byte_off_nxt;
      in_run_r    <= in_run_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        min_len_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    emit_n_r     <= emit_n_nxt;
    cnt_r        <= cnt_nxt;
    pend_kind_r  <= pend_kind_nxt;
    pend_value_r <= pend_value_nxt;
    pend_last_r  <= pend_last_nxt;
    out_kind_r   <= out_kind_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  // a reported run keeps the window empty
  a_run_window_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_run_r |-> (fill_r == '0))
    else $error("window not empty inside a reported run");

  // a waiting word that is not last belongs to a report readout
  a_not_last_in_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |-> (state_r == S_CHR))
    else $error("non-final word outside a report");

  // offset word is always followed by window characters
  a_offset_then_chars: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && (out_ch.kind == KIND_OFFSET)) |->
      (state_r == S_CHR))
    else $error("offset word without readout");

  // readout counter stays within the reported window
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHR) |-> ((cnt_r != '0) && (cnt_r <= emit_n_r) &&
                            (emit_n_r <= CW'(MAX_WINDOW))))
    else $error("readout counter out of range");

endmodule

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pex_pkg::*;

  localparam int WINDOW_DEPTH = 16;
  localparam int MAX_GAP      = 14;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES   = 40;
  localparam int STALL_LIMIT  = 1000;

  typedef struct packed {
    logic  func;
    byte_t data;
    logic  drain;
  } byte_item_t;

  typedef struct packed {
    kind_t  kind;
    value_t value;
    logic   last;
  } result_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  len_t cfg_data;

  pex_in_if  in_bus ();
  pex_out_if out_bus ();

  printable_run_extractor #(.MAX_WINDOW(WINDOW_DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_bus),
    .out_ch   (out_bus)
  );

  // words waiting to be sent and results still owed by the block
  byte_item_t   byte_queue[$];
  result_word_t expected_words[$];

  // shadow copy of the run tracking state
  byte_t  run_window[WINDOW_DEPTH] = '{default: 8'h00};
  int     run_fill = 0;
  logic   run_alnum = 1'b0;
  value_t run_offset = 16'd0;
  logic   run_open = 1'b0;
  len_t   run_min_len;

  int   mismatches = 0;
  logic in_steady;
  logic out_steady;
  logic drain_next;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic text_byte(byte_t c);
    return (c >= CHAR_SPACE) && (c < CHAR_DEL);
  endfunction

  function automatic logic word_byte(byte_t c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic void add_result(kind_t k, value_t v);
    result_word_t w;
    w.kind  = k;
    w.value = v;
    w.last  = 1'b0;
    expected_words.push_back(w);
  endfunction

  // advance the shadow state by one accepted word and queue the results it owes
  function automatic void track_runs(logic func, byte_t b);
    int     start_len;
    int     eff_len;
    value_t here;
    start_len = expected_words.size();
    here = run_offset;
    if (func == FUNC_EOF) begin
      if (run_open) add_result(KIND_EOL, 16'd0);
      run_fill   = 0;
      run_alnum  = 1'b0;
      run_open   = 1'b0;
      run_offset = 16'd0;
    end else begin
      run_offset = run_offset + 16'd1;
      if (run_open) begin
        if (text_byte(b)) begin
          add_result(KIND_CHAR, {8'd0, b});
        end else begin
          add_result(KIND_EOL, 16'd0);
          run_open  = 1'b0;
          run_fill  = 0;
          run_alnum = 1'b0;
        end
      end else if (!text_byte(b)) begin
        run_fill  = 0;
        run_alnum = 1'b0;
      end else begin
        if (run_fill < WINDOW_DEPTH) begin
          run_window[run_fill] = b;
          run_fill++;
        end
        if (word_byte(b)) run_alnum = 1'b1;
        // out-of-range lengths clamp to 1..WINDOW_DEPTH
        if (run_min_len == 0) eff_len = 1;
        else if (run_min_len > WINDOW_DEPTH) eff_len = WINDOW_DEPTH;
        else eff_len = run_min_len;
        if (run_fill >= eff_len) begin
          if (run_alnum) begin
            add_result(KIND_OFFSET, here + 16'd1 - 16'(run_fill));
            for (int k = 0; k < run_fill; k++) add_result(KIND_CHAR, {8'd0, run_window[k]});
            run_open = 1'b1;
          end
          run_fill  = 0;
          run_alnum = 1'b0;
        end
      end
    end
    if (expected_words.size() > start_len) expected_words[$].last = 1'b1;
  endfunction

  // driver: presents queued words, a drain-marked word waits for all results
  always @(posedge clk) begin : driver
    int gap;
    byte_item_t item;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        track_runs(in_bus.func, in_bus.byte_value);
        gap = in_steady ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap > 0) begin
          gap--;
          in_bus.valid <= 1'b0;
        end else if (byte_queue.size() != 0 &&
                     !(byte_queue[0].drain && expected_words.size() != 0)) begin
          item = byte_queue.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.func       <= item.func;
          in_bus.byte_value <= item.data;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result word against the oldest expectation
  always @(posedge clk) begin : monitor
    int stall;
    result_word_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: kind %0d value %0h last %0b",
                 out_bus.kind, out_bus.value, out_bus.last);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (out_bus.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_bus.kind);
            mismatches++;
          end
          if (out_bus.value !== want.value) begin
            $error("value: expected %0h, got %0h", want.value, out_bus.value);
            mismatches++;
          end
          if (out_bus.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_bus.last);
            mismatches++;
          end
        end
        stall = out_steady ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        stall--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake and no register write
  always @(posedge clk) begin : watchdog
    int quiet;
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || cfg_we) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic push_word(logic func, byte_t b);
    byte_item_t item;
    item.func  = func;
    item.data  = b;
    item.drain = drain_next;
    drain_next = 1'b0;
    byte_queue.push_back(item);
  endtask

  task automatic push_byte(byte_t b);
    push_word(FUNC_DATA, b);
  endtask

  task automatic push_eof();
    push_word(FUNC_EOF, byte_t'($urandom_range(0, 255)));
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(byte_t'(s[i]));
  endtask

  // wait until the block has nothing in flight
  task automatic drain_and_settle(int cycles);
    do @(negedge clk);
    while (byte_queue.size() != 0 || in_bus.valid || expected_words.size() != 0);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_min_len(len_t v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    run_min_len = v;
  endtask

  function automatic byte_t pick_printable(logic want_alnum);
    byte_t c;
    do c = byte_t'($urandom_range(32, 126));
    while (word_byte(c) != want_alnum);
    return c;
  endfunction

  function automatic byte_t pick_control();
    if ($urandom_range(0, 1) == 0) return byte_t'($urandom_range(0, 31));
    return byte_t'($urandom_range(127, 255));
  endfunction

  // mostly printable runs with random content, some noise and bare eofs
  task automatic queue_random_stream(int n);
    int count;
    int run_len;
    count = 0;
    while (count < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          run_len = $urandom_range(1, 20);
          for (int i = 0; i < run_len; i++)
            push_byte(pick_printable($urandom_range(0, 3) != 0));
          if ($urandom_range(0, 4) == 0) push_eof();
          else push_byte(pick_control());
          count += run_len + 1;
        end
        7: begin
          push_byte(byte_t'($urandom_range(0, 255)));
          count++;
        end
        8: begin
          push_eof();
          count++;
        end
        default: begin
          drain_next = 1'b1;
        end
      endcase
    end
  endtask

  task automatic random_phase(len_t v, int n);
    drain_and_settle(SETTLE_CYCLES);
    write_min_len(v);
    in_steady  = ($urandom_range(0, 3) == 0);
    out_steady = ($urandom_range(0, 3) == 0);
    queue_random_stream(n);
  endtask

  // stimulus sequence
  initial begin
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_data = MIN_LEN_RESET;
    in_steady   = 1'b0;
    out_steady  = 1'b0;
    drain_next  = 1'b0;
    run_min_len = MIN_LEN_RESET;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at the reset length
    push_text("Ab1x");
    push_byte(CHAR_SPACE);
    push_byte(8'h7E);
    push_byte(CHAR_DEL);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("!!~ ");
    drain_next = 1'b1;
    push_text("zZ9");
    push_byte(8'h1F);
    push_text("Q012");
    push_eof();
    push_eof();
    push_text("a9");
    push_eof();

    // length lowered while a window is partly filled
    drain_and_settle(SETTLE_CYCLES);
    write_min_len(5'd8);
    push_text("abcde");
    drain_and_settle(SETTLE_CYCLES);
    write_min_len(5'd3);
    push_text("f");
    push_byte(8'h0A);

    // random phases over the extremes and beyond the meaningful range
    random_phase(5'd16, 18);
    random_phase(5'd0, 15);
    random_phase(5'd31, 15);
    random_phase(len_t'($urandom_range(0, 31)), 15);
    random_phase(5'd1, 15);

    drain_and_settle(END_CYCLES);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
